// File: hdl/wmr_pkg.sv
// ----------------------------------------------------------------------------
// wmr_pkg: shared types and constants of the windowed mean and rms unit
// sequencer states, register map and fixed field widths
// ----------------------------------------------------------------------------
package wmr_pkg;

   // register map: one 32-bit register every 4 bytes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_WINDOW_LENGTH = 1'b0;
   localparam logic CSR_RMS_MODE      = 1'b1;

   localparam int CFG_LEN_W = 9;
   localparam logic [CFG_LEN_W-1:0] LEN_RESET = 9'd256;

   // peak starts at minus this value
   localparam int PEAK_START = 100;

   // shared compare-subtract unit
   localparam int WORK_W = 64;
   localparam int REM_W  = 35;
   localparam int ROOT_W = 32;
   localparam int DIV_W  = 32;
   localparam int ITER_W = 6;

   // result field widths
   localparam int MEAN_OUT_W = 32;
   localparam int ROOT_OUT_W = 16;
   localparam int OCNT_W     = 32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_WSETUP,
      ST_WDIV,
      ST_WFIX,
      ST_WSQRT,
      ST_OSETUP,
      ST_ODIV,
      ST_OFIX,
      ST_OSQRT,
      ST_FINISH
   } state_type;

endpackage

// File: hdl/wmr_ram.sv
// ----------------------------------------------------------------------------
// wmr_ram: generic single-port-write ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module wmr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/windowed_mean_and_rms_unit.sv
// ----------------------------------------------------------------------------
// windowed_mean_and_rms_unit: windowed and running mean / rms of samples
// items: one at a time; req_stall stays high from acceptance until the result is
//   written to the result item register, so no new item enters before then
// all arithmetic goes through the shared one-bit-per-cycle compare-subtract unit
//   that runs both divisions and both square roots
// reset: synchronous; clears totals and handshake state, window_length 256,
//   rms_mode 0; no ring clearing pass, entries past the fill count read as zero
// ----------------------------------------------------------------------------
module windowed_mean_and_rms_unit #(
   parameter int WINDOW_MAX  = 256,
   parameter int SAMPLE_BITS = 16,
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1),
   localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
   input  logic                                  clock,
   input  logic                                  reset,

   // input item channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample,
   input  logic                                  req_clear,

   // result item channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [wmr_pkg::MEAN_OUT_W-1:0] rsp_window_mean,
   output logic [wmr_pkg::ROOT_OUT_W-1:0]        rsp_window_root,
   output logic signed [wmr_pkg::MEAN_OUT_W-1:0] rsp_overall_mean,
   output logic [wmr_pkg::ROOT_OUT_W-1:0]        rsp_overall_root,
   output logic signed [wmr_pkg::MEAN_OUT_W-1:0] rsp_peak_value,
   output logic [CNT_W-1:0]                      rsp_window_fill,

   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wmr_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [wmr_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [wmr_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   // stored value: the sample, or its square, as a signed word
   localparam int VAL_W   = 2 * SAMPLE_BITS;
   // window sum grows by the fill count bits, wraps at 64 like the totals
   localparam int WS_FULL = VAL_W + CNT_W;
   localparam int WS_W    = (WS_FULL > 64) ? 64 : WS_FULL;
   localparam int WS_SHIFT = wmr_pkg::WORK_W - WS_W;
   // root iterations: the mean stays inside the value range unless a sum can wrap
   localparam int WSQ_K = (WS_FULL > 64) ? 32 : SAMPLE_BITS;
   localparam int OSQ_K = (2 * SAMPLE_BITS + 30 > 62) ? 32 : SAMPLE_BITS;
   localparam int WSQ_SHIFT = wmr_pkg::WORK_W - 2 * WSQ_K;
   localparam int OSQ_SHIFT = wmr_pkg::WORK_W - 2 * OSQ_K;
   // common width for comparing the length register against the window size
   localparam int LC_W = (CNT_W > wmr_pkg::CFG_LEN_W) ? CNT_W : wmr_pkg::CFG_LEN_W;

   localparam logic signed [VAL_W-1:0] PEAK_INIT = VAL_W'(-wmr_pkg::PEAK_START);

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   wmr_pkg::state_type state_ff, state_in;

   logic [wmr_pkg::CFG_LEN_W-1:0]   wlen_ff, wlen_in;
   logic                            rms_ff, rms_in;

   logic signed [WS_W-1:0]          wsum_ff, wsum_in;
   logic [ADDR_W-1:0]               wpos_ff, wpos_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic [63:0]                     osum_ff, osum_in;
   logic [wmr_pkg::OCNT_W-1:0]      ocnt_ff, ocnt_in;
   logic signed [VAL_W-1:0]         peak_ff, peak_in;

   logic signed [SAMPLE_BITS-1:0]   sample_ff, sample_in;
   logic signed [VAL_W-1:0]         val_ff, val_in;

   // shared unit operands
   logic [wmr_pkg::REM_W-1:0]       rem_ff, rem_in;
   logic [wmr_pkg::WORK_W-1:0]      work_ff, work_in;
   logic [wmr_pkg::ROOT_W-1:0]      root_ff, root_in;
   logic [wmr_pkg::DIV_W-1:0]       div_ff, div_in;
   logic [wmr_pkg::ITER_W-1:0]      iter_ff, iter_in;
   logic                            neg_ff, neg_in;

   // partial results
   logic [wmr_pkg::MEAN_OUT_W-1:0]  wmean_ff, wmean_in;
   logic [wmr_pkg::ROOT_OUT_W-1:0]  wroot_ff, wroot_in;
   logic [wmr_pkg::MEAN_OUT_W-1:0]  omean_ff, omean_in;

   // result item register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wmr_pkg::MEAN_OUT_W-1:0]  rsp_wmean_ff, rsp_wmean_in;
   logic [wmr_pkg::ROOT_OUT_W-1:0]  rsp_wroot_ff, rsp_wroot_in;
   logic [wmr_pkg::MEAN_OUT_W-1:0]  rsp_omean_ff, rsp_omean_in;
   logic [wmr_pkg::ROOT_OUT_W-1:0]  rsp_oroot_ff, rsp_oroot_in;
   logic [wmr_pkg::MEAN_OUT_W-1:0]  rsp_peak_ff, rsp_peak_in;
   logic [CNT_W-1:0]                rsp_fill_ff, rsp_fill_in;

   // ------------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------------
   logic accept_req;
   logic cfg_wr;
   logic cfg_idx;

   assign req_stall  = (state_ff != wmr_pkg::ST_IDLE);
   assign accept_req = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   // 4-byte register spacing: bit 2 picks the register
   assign cfg_idx    = csr_paddr[2];

   always_comb begin
      case (cfg_idx)
         wmr_pkg::CSR_WINDOW_LENGTH: csr_prdata = wmr_pkg::CSR_DATA_W'(wlen_ff);
         wmr_pkg::CSR_RMS_MODE:      csr_prdata = wmr_pkg::CSR_DATA_W'(rms_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // effective window length: zero acts as one, clipped to the ring depth
   // ------------------------------------------------------------------------
   logic [LC_W-1:0]  wlen_ext;
   logic [LC_W-1:0]  len_ext;
   logic [CNT_W-1:0] len_eff;

   always_comb begin
      wlen_ext = LC_W'(wlen_ff);
      if (wlen_ext == '0) begin
         len_ext = LC_W'(1);
      end else if (wlen_ext > LC_W'(WINDOW_MAX)) begin
         len_ext = LC_W'(WINDOW_MAX);
      end else begin
         len_ext = wlen_ext;
      end
      len_eff = CNT_W'(len_ext);
   end

   // ------------------------------------------------------------------------
   // stored value: plain sample or squared magnitude
   // ------------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0]  sample_mag;
   logic [VAL_W-1:0]        sample_sq;
   logic signed [VAL_W-1:0] value_calc;

   always_comb begin
      // the most negative sample negates onto its own unsigned magnitude
      sample_mag = sample_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_ff)
                                            : SAMPLE_BITS'(sample_ff);
      sample_sq  = VAL_W'(sample_mag) * VAL_W'(sample_mag);
      value_calc = rms_ff ? $signed(sample_sq) : VAL_W'(sample_ff);
   end

   // ------------------------------------------------------------------------
   // ring of stored values
   // ------------------------------------------------------------------------
   logic                    ring_we;
   logic [VAL_W-1:0]        ring_rdata;
   logic signed [VAL_W-1:0] old_val;

   wmr_ram #(
      .WIDTH (VAL_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wpos_ff),
      .wr_data (val_ff),
      .rd_addr (wpos_ff),
      .rd_data (ring_rdata)
   );

   // until the window has wrapped, the slot under the write position has
   // not been written since the last clear and counts as zero
   assign old_val = (fill_ff < len_eff) ? '0 : $signed(ring_rdata);

   logic [CNT_W-1:0] wpos_inc;
   assign wpos_inc = CNT_W'(wpos_ff) + CNT_W'(1);

   // ------------------------------------------------------------------------
   // shared compare-subtract unit
   // restoring division: one quotient bit a cycle from the top of work_ff
   // square root: two radicand bits a cycle against (root << 2) | 1
   // ------------------------------------------------------------------------
   logic                      is_div;
   logic [wmr_pkg::REM_W-1:0] cs_shift;
   logic [wmr_pkg::REM_W-1:0] cs_sub;
   logic [wmr_pkg::REM_W:0]   cs_diff;
   logic                      cs_ok;

   assign is_div = (state_ff == wmr_pkg::ST_WDIV) || (state_ff == wmr_pkg::ST_ODIV);

   always_comb begin
      if (is_div) begin
         cs_shift = {rem_ff[wmr_pkg::REM_W-2:0], work_ff[wmr_pkg::WORK_W-1]};
         cs_sub   = wmr_pkg::REM_W'(div_ff);
      end else begin
         cs_shift = {rem_ff[wmr_pkg::REM_W-3:0], work_ff[wmr_pkg::WORK_W-1 -: 2]};
         cs_sub   = wmr_pkg::REM_W'({root_ff, 2'b01});
      end
      cs_diff = {1'b0, cs_shift} - {1'b0, cs_sub};
      cs_ok   = !cs_diff[wmr_pkg::REM_W];
   end

   // quotient sign fix and root operand, used after both divisions
   logic [wmr_pkg::WORK_W-1:0] fix_mean;
   logic                       fix_pos;

   assign fix_mean = neg_ff ? (-work_ff) : work_ff;
   assign fix_pos  = !fix_mean[wmr_pkg::WORK_W-1] && (fix_mean != '0);

   // magnitudes of the two dividends
   logic [WS_W-1:0]            wsum_mag;
   logic [wmr_pkg::WORK_W-1:0] osum_mag;

   assign wsum_mag = wsum_ff[WS_W-1] ? WS_W'(-wsum_ff) : WS_W'(wsum_ff);
   assign osum_mag = osum_ff[63] ? (-osum_ff) : osum_ff;

   // ------------------------------------------------------------------------
   // sequencer and datapath next values
   // ------------------------------------------------------------------------
   logic clear_totals;

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      rms_in       = rms_ff;
      wsum_in      = wsum_ff;
      wpos_in      = wpos_ff;
      fill_in      = fill_ff;
      osum_in      = osum_ff;
      ocnt_in      = ocnt_ff;
      peak_in      = peak_ff;
      sample_in    = sample_ff;
      val_in       = val_ff;
      rem_in       = rem_ff;
      work_in      = work_ff;
      root_in      = root_ff;
      div_in       = div_ff;
      iter_in      = iter_ff;
      neg_in       = neg_ff;
      wmean_in     = wmean_ff;
      wroot_in     = wroot_ff;
      omean_in     = omean_ff;
      rsp_wmean_in = rsp_wmean_ff;
      rsp_wroot_in = rsp_wroot_ff;
      rsp_omean_in = rsp_omean_ff;
      rsp_oroot_in = rsp_oroot_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_fill_in  = rsp_fill_ff;
      // a waiting result leaves once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ring_we      = 1'b0;
      clear_totals = 1'b0;

      case (state_ff)
         wmr_pkg::ST_IDLE: begin
            if (accept_req) begin
               if (req_clear) begin
                  // cleared state goes straight to the result math
                  clear_totals = 1'b1;
                  state_in     = wmr_pkg::ST_WSETUP;
               end else begin
                  sample_in = req_sample;
                  state_in  = wmr_pkg::ST_READ;
               end
            end
         end

         wmr_pkg::ST_READ: begin
            // ring slot under the write position is read this cycle
            val_in   = value_calc;
            state_in = wmr_pkg::ST_UPDATE;
         end

         wmr_pkg::ST_UPDATE: begin
            wsum_in = wsum_ff - WS_W'(old_val) + WS_W'(val_ff);
            ring_we = 1'b1;
            if (wpos_inc >= len_eff) begin
               wpos_in = '0;
            end else begin
               wpos_in = ADDR_W'(wpos_inc);
            end
            if (fill_ff < len_eff) begin
               fill_in = fill_ff + CNT_W'(1);
            end
            if (val_ff > peak_ff) begin
               peak_in = val_ff;
            end
            // running totals freeze once the count saturates
            if (ocnt_ff != '1) begin
               osum_in = osum_ff + 64'(val_ff);
               ocnt_in = ocnt_ff + wmr_pkg::OCNT_W'(1);
            end
            state_in = wmr_pkg::ST_WSETUP;
         end

         wmr_pkg::ST_WSETUP: begin
            neg_in  = wsum_ff[WS_W-1];
            work_in = wmr_pkg::WORK_W'(wsum_mag) << WS_SHIFT;
            // empty window: sum is zero, divide by one for a zero mean
            div_in  = (fill_ff == '0) ? wmr_pkg::DIV_W'(1) : wmr_pkg::DIV_W'(fill_ff);
            rem_in  = '0;
            iter_in = wmr_pkg::ITER_W'(WS_W - 1);
            state_in = wmr_pkg::ST_WDIV;
         end

         wmr_pkg::ST_WDIV, wmr_pkg::ST_ODIV: begin
            rem_in  = cs_ok ? cs_diff[wmr_pkg::REM_W-1:0] : cs_shift;
            work_in = {work_ff[wmr_pkg::WORK_W-2:0], cs_ok};
            iter_in = iter_ff - wmr_pkg::ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = (state_ff == wmr_pkg::ST_WDIV) ? wmr_pkg::ST_WFIX
                                                          : wmr_pkg::ST_OFIX;
            end
         end

         wmr_pkg::ST_WFIX: begin
            wmean_in = fix_mean[wmr_pkg::MEAN_OUT_W-1:0];
            // negative or zero mean roots to zero
            work_in  = fix_pos ? (fix_mean << WSQ_SHIFT) : '0;
            rem_in   = '0;
            root_in  = '0;
            iter_in  = wmr_pkg::ITER_W'(WSQ_K - 1);
            state_in = wmr_pkg::ST_WSQRT;
         end

         wmr_pkg::ST_WSQRT, wmr_pkg::ST_OSQRT: begin
            rem_in  = cs_ok ? cs_diff[wmr_pkg::REM_W-1:0] : cs_shift;
            root_in = {root_ff[wmr_pkg::ROOT_W-2:0], cs_ok};
            work_in = work_ff << 2;
            iter_in = iter_ff - wmr_pkg::ITER_W'(1);
            if (iter_ff == '0) begin
               state_in = (state_ff == wmr_pkg::ST_WSQRT) ? wmr_pkg::ST_OSETUP
                                                           : wmr_pkg::ST_FINISH;
            end
         end

         wmr_pkg::ST_OSETUP: begin
            wroot_in = root_ff[wmr_pkg::ROOT_OUT_W-1:0];
            neg_in   = osum_ff[63];
            work_in  = osum_mag;
            div_in   = (ocnt_ff == '0) ? wmr_pkg::DIV_W'(1) : wmr_pkg::DIV_W'(ocnt_ff);
            rem_in   = '0;
            iter_in  = wmr_pkg::ITER_W'(wmr_pkg::WORK_W - 1);
            state_in = wmr_pkg::ST_ODIV;
         end

         wmr_pkg::ST_OFIX: begin
            omean_in = fix_mean[wmr_pkg::MEAN_OUT_W-1:0];
            work_in  = fix_pos ? (fix_mean << OSQ_SHIFT) : '0;
            rem_in   = '0;
            root_in  = '0;
            iter_in  = wmr_pkg::ITER_W'(OSQ_K - 1);
            state_in = wmr_pkg::ST_OSQRT;
         end

         wmr_pkg::ST_FINISH: begin
            // wait here only while the previous result is still held
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_wmean_in = wmean_ff;
               rsp_wroot_in = wroot_ff;
               rsp_omean_in = omean_ff;
               rsp_oroot_in = root_ff[wmr_pkg::ROOT_OUT_W-1:0];
               rsp_peak_in  = wmr_pkg::MEAN_OUT_W'(peak_ff);
               rsp_fill_in  = fill_ff;
               state_in     = wmr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wmr_pkg::ST_IDLE;
         end
      endcase

      // configuration writes: to be made only while idle, which the block itself does not enforce
      if (cfg_wr) begin
         case (cfg_idx)
            wmr_pkg::CSR_WINDOW_LENGTH: begin
               wlen_in      = csr_pwdata[wmr_pkg::CFG_LEN_W-1:0];
               clear_totals = 1'b1;
            end
            wmr_pkg::CSR_RMS_MODE: begin
               rms_in = csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end

      if (clear_totals) begin
         wsum_in = '0;
         wpos_in = '0;
         fill_in = '0;
         osum_in = '0;
         ocnt_in = '0;
         peak_in = PEAK_INIT;
      end
   end

   // ------------------------------------------------------------------------
   // state registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wmr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wlen_ff      <= wmr_pkg::LEN_RESET;
         rms_ff       <= 1'b0;
         wsum_ff      <= '0;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         osum_ff      <= '0;
         ocnt_ff      <= '0;
         peak_ff      <= PEAK_INIT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wlen_ff      <= wlen_in;
         rms_ff       <= rms_in;
         wsum_ff      <= wsum_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         osum_ff      <= osum_in;
         ocnt_ff      <= ocnt_in;
         peak_ff      <= peak_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      val_ff       <= val_in;
      rem_ff       <= rem_in;
      work_ff      <= work_in;
      root_ff      <= root_in;
      div_ff       <= div_in;
      iter_ff      <= iter_in;
      neg_ff       <= neg_in;
      wmean_ff     <= wmean_in;
      wroot_ff     <= wroot_in;
      omean_ff     <= omean_in;
      rsp_wmean_ff <= rsp_wmean_in;
      rsp_wroot_ff <= rsp_wroot_in;
      rsp_omean_ff <= rsp_omean_in;
      rsp_oroot_ff <= rsp_oroot_in;
      rsp_peak_ff  <= rsp_peak_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   // ------------------------------------------------------------------------
   // outputs
   // ------------------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_mean  = $signed(rsp_wmean_ff);
   assign rsp_window_root  = rsp_wroot_ff;
   assign rsp_overall_mean = $signed(rsp_omean_ff);
   assign rsp_overall_root = rsp_oroot_ff;
   assign rsp_peak_value   = $signed(rsp_peak_ff);
   assign rsp_window_fill  = rsp_fill_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // fill count never passes the effective window length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= len_eff)
      else $error("window fill above window length");

   // write position stays inside the window
   a_wpos_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(wpos_ff) < len_eff)
      else $error("write position outside window");

   // an empty window holds a zero sum
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0) |-> (wsum_ff == '0))
      else $error("empty window with nonzero sum");

   // an insert item reads the ring and then updates the totals
   a_insert_seq: assert property (@(posedge clock) disable iff (reset)
      (accept_req && !req_clear) |=>
         (state_ff == wmr_pkg::ST_READ) ##1 (state_ff == wmr_pkg::ST_UPDATE))
      else $error("insert item skipped ring read or update");

   // a result appears only out of the final sequencer step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == wmr_pkg::ST_FINISH))
      else $error("result raised outside finish step");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the windowed mean and rms unit
// drives sample and clear items, predicts every result item from a behavioral
// copy of the window ring, running totals and peak, and checks each field
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIN_DEPTH     = 256;
   localparam int SAMPLE_W      = 16;
   localparam int FILL_W        = $clog2(WIN_DEPTH + 1);
   // receiver hold-off for the backpressure test, well past one item's latency
   localparam int HOLD_CYCLES   = 2000;
   // cycles with no item accepted on either channel before the run is abandoned
   localparam int STALL_LIMIT   = 10000;
   // quiet time after the last result, a bit more than one item's latency
   localparam int TAIL_CYCLES   = 160;

   // one result item as seen on the rsp_ ports
   typedef struct {
      logic signed [wmr_pkg::MEAN_OUT_W-1:0] window_mean;
      logic [wmr_pkg::ROOT_OUT_W-1:0]        window_root;
      logic signed [wmr_pkg::MEAN_OUT_W-1:0] overall_mean;
      logic [wmr_pkg::ROOT_OUT_W-1:0]        overall_root;
      logic signed [wmr_pkg::MEAN_OUT_W-1:0] peak_value;
      logic [FILL_W-1:0]                     window_fill;
   } stats_type;

   // ------------------------------------------------------------------------
   // clock, reset and block ports
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_valid   = 1'b0;
   logic                                  req_stall;
   logic signed [SAMPLE_W-1:0]            req_sample  = '0;
   logic                                  req_clear   = 1'b0;

   logic                                  rsp_valid;
   logic                                  rsp_stall   = 1'b0;
   logic signed [wmr_pkg::MEAN_OUT_W-1:0] rsp_window_mean;
   logic [wmr_pkg::ROOT_OUT_W-1:0]        rsp_window_root;
   logic signed [wmr_pkg::MEAN_OUT_W-1:0] rsp_overall_mean;
   logic [wmr_pkg::ROOT_OUT_W-1:0]        rsp_overall_root;
   logic signed [wmr_pkg::MEAN_OUT_W-1:0] rsp_peak_value;
   logic [FILL_W-1:0]                     rsp_window_fill;

   logic                                  csr_psel    = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite  = 1'b0;
   logic [wmr_pkg::CSR_ADDR_W-1:0]        csr_paddr   = '0;
   logic [wmr_pkg::CSR_DATA_W-1:0]        csr_pwdata  = '0;
   logic [wmr_pkg::CSR_DATA_W-1:0]        csr_prdata;
   logic                                  csr_pready;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   windowed_mean_and_rms_unit #(
      .WINDOW_MAX  (WIN_DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_clear        (req_clear),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_mean  (rsp_window_mean),
      .rsp_window_root  (rsp_window_root),
      .rsp_overall_mean (rsp_overall_mean),
      .rsp_overall_root (rsp_overall_root),
      .rsp_peak_value   (rsp_peak_value),
      .rsp_window_fill  (rsp_window_fill),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   int        fail_count         = 0;
   int        sender_idle_pct    = 0;
   int        receiver_stall_pct = 0;
   int        hold_requests      = 0;
   int        hold_served        = 0;
   int        hold_left          = 0;
   int        quiet_cycles       = 0;
   stats_type expected_stats[$];

   // behavioral copy of the block: ring, window and running totals, peak
   logic [63:0]                   ring_vals [WIN_DEPTH];
   logic [63:0]                   win_total;
   int unsigned                   wr_ptr;
   int unsigned                   win_count;
   logic [63:0]                   run_total;
   logic [wmr_pkg::OCNT_W-1:0]    run_count;
   longint                        peak_val;
   logic [wmr_pkg::CFG_LEN_W-1:0] cfg_len;
   logic                          cfg_rms;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void clear_totals();
      foreach (ring_vals[i]) ring_vals[i] = '0;
      win_total = '0;
      wr_ptr    = 0;
      win_count = 0;
      run_total = '0;
      run_count = '0;
      peak_val  = -wmr_pkg::PEAK_START;
   endfunction

   // out-of-range lengths: zero behaves as one, anything past the ring as full
   function automatic int unsigned active_length();
      if (cfg_len == 0) return 1;
      if (cfg_len > WIN_DEPTH) return WIN_DEPTH;
      return cfg_len;
   endfunction

   // truncating signed mean, zero for an empty count
   function automatic longint mean_of_totals(input logic [63:0] total,
                                             input longint unsigned n);
      if (n == 0) return 0;
      return $signed(total) / longint'(n);
   endfunction

   // floor square root, zero for a non-positive mean
   function automatic logic [wmr_pkg::ROOT_OUT_W-1:0] floor_root(input longint m);
      longint unsigned v, res, step;
      if (m <= 0) return '0;
      v    = m;
      res  = 0;
      step = 64'h4000_0000_0000_0000;
      while (step > v) step >>= 2;
      while (step != 0) begin
         if (v >= res + step) begin
            v   = v - (res + step);
            res = (res >> 1) + step;
         end else begin
            res >>= 1;
         end
         step >>= 2;
      end
      return res[wmr_pkg::ROOT_OUT_W-1:0];
   endfunction

   // apply one accepted item and queue the result it should produce
   function automatic void predict_stats(input logic signed [SAMPLE_W-1:0] smp,
                                         input logic clr);
      longint      s;
      logic [63:0] stored;
      int unsigned len;
      longint      w_mean, o_mean;
      stats_type   r;
      if (clr) begin
         clear_totals();
      end else begin
         s   = smp;
         len = active_length();
         // rms mode keeps the square, plain mode the sample itself
         stored = cfg_rms ? 64'(s * s) : 64'(s);
         if (wr_ptr >= len) wr_ptr = 0;
         win_total = win_total - ring_vals[wr_ptr] + stored;
         ring_vals[wr_ptr] = stored;
         wr_ptr++;
         if (wr_ptr >= len) wr_ptr = 0;
         if (win_count < len) win_count++;
         if ($signed(stored) > peak_val) peak_val = $signed(stored);
         // running totals freeze once the count is saturated
         if (run_count != '1) begin
            run_total = run_total + stored;
            run_count = run_count + 1'b1;
         end
      end
      w_mean         = mean_of_totals(win_total, win_count);
      o_mean         = mean_of_totals(run_total, run_count);
      r.window_mean  = w_mean[wmr_pkg::MEAN_OUT_W-1:0];
      r.window_root  = floor_root(w_mean);
      r.overall_mean = o_mean[wmr_pkg::MEAN_OUT_W-1:0];
      r.overall_root = floor_root(o_mean);
      r.peak_value   = peak_val[wmr_pkg::MEAN_OUT_W-1:0];
      r.window_fill  = win_count[FILL_W-1:0];
      expected_stats.push_back(r);
   endfunction

   // ------------------------------------------------------------------------
   // driving side
   // ------------------------------------------------------------------------

   // offer one item, with random idle cycles ahead of it; valid is left high
   // on return so back-to-back items keep it asserted
   task automatic send_item(input logic signed [SAMPLE_W-1:0] smp,
                            input logic clr);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      req_clear  <= clr;
      do @(posedge clock); while (req_stall);
      predict_stats(smp, clr);
   endtask

   // drop valid and wait for every outstanding result item
   task automatic wait_results_drained();
      if (expected_stats.size() != 0) begin
         req_valid <= 1'b0;
         while (expected_stats.size() != 0) @(posedge clock);
      end
   endtask

   // register write: setup then access phase, only with the block idle
   task automatic write_csr(input logic idx,
                            input logic [wmr_pkg::CSR_DATA_W-1:0] value);
      wait_results_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= wmr_pkg::CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == wmr_pkg::CSR_WINDOW_LENGTH) begin
         // a length write also wipes the ring and all totals
         cfg_len = value[wmr_pkg::CFG_LEN_W-1:0];
         clear_totals();
      end else begin
         cfg_rms = value[0];
      end
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'(int'($urandom_range(400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly legal lengths, now and then a raw 9-bit value (zero, past the ring)
   function automatic logic [wmr_pkg::CFG_LEN_W-1:0] pick_length();
      case ($urandom_range(7))
         0:       return 9'd1;
         1:       return 9'd2;
         2:       return 9'd256;
         3:       return 9'($urandom_range(16, 3));
         4:       return 9'($urandom);
         default: return 9'($urandom_range(256, 1));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // receiver pacing: random stalls, or a long hold-off on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // result checking, oldest expectation first
   // ------------------------------------------------------------------------
   task automatic compare_field(input string name,
                                input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (want !== got) begin
         fail_count++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_stats.size() == 0) begin
            fail_count++;
            $error("result item arrived with nothing outstanding");
         end else begin
            want = expected_stats.pop_front();
            compare_field("window_mean",  want.window_mean,  rsp_window_mean);
            compare_field("window_root",  want.window_root,  rsp_window_root);
            compare_field("overall_mean", want.overall_mean, rsp_overall_mean);
            compare_field("overall_root", want.overall_root, rsp_overall_root);
            compare_field("peak_value",   want.peak_value,   rsp_peak_value);
            compare_field("window_fill",  want.window_fill,  rsp_window_fill);
         end
      end
   end

   // abandon the run if neither channel moves an item for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $error("no item accepted for %0d cycles", STALL_LIMIT);
         $display("tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // clear item straight after reset: cleared state, sample ignored
   task automatic test_cleared_state();
      send_item(16'sh1234, 1'b1);
   endtask

   // plain mode at the reset length: extremes, negative means, peak floor
   task automatic test_plain_extremes();
      send_item(-16'sd200, 1'b0);    // below the peak floor, peak stays put
      send_item(16'sh8000, 1'b0);    // negative means, roots forced to zero
      send_item(-16'sd1, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sd1, 1'b0);
      send_item(16'sh5A5A, 1'b1);    // clear in the middle of a window
   endtask

   // single-entry window of squares: largest square, root of 32768
   task automatic test_square_extremes();
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'd1);
      write_csr(wmr_pkg::CSR_RMS_MODE, 32'd1);
      send_item(16'sh8000, 1'b0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(-16'sd1, 1'b0);
   endtask

   // length zero acts as one, past the ring acts as full, small ring wraps
   task automatic test_length_limits();
      write_csr(wmr_pkg::CSR_RMS_MODE, 32'd0);
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'd0);
      send_item(16'sd300, 1'b0);
      send_item(-16'sd7, 1'b0);
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'd400);
      send_item(16'sd9, 1'b0);
      send_item(-16'sd4, 1'b0);
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'd2);
      send_item(16'sd10, 1'b0);
      send_item(16'sd20, 1'b0);
      send_item(16'sd31, 1'b0);
   endtask

   // mode switch keeps the window: plain and squared values mix
   task automatic test_mode_switch();
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'd4);
      send_item(-16'sd5, 1'b0);
      write_csr(wmr_pkg::CSR_RMS_MODE, 32'd1);
      send_item(16'sd3, 1'b0);
      send_item(16'sd0, 1'b1);
   endtask

   // full 256-entry window of squares, well past wrap-around
   task automatic test_window_fill();
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'(wmr_pkg::LEN_RESET));
      write_csr(wmr_pkg::CSR_RMS_MODE, 32'd1);
      repeat (280) send_item(pick_sample(), 1'b0);
   endtask

   // random items under one idling pattern, over a few register settings
   task automatic test_random_traffic(input int send_pct, input int stall_pct);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      for (int seg = 0; seg < 3; seg++) begin
         // a length write clears; a mode write alone keeps the window
         if (seg == 0 || $urandom_range(1) == 1)
            write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'(pick_length()));
         write_csr(wmr_pkg::CSR_RMS_MODE, 32'($urandom_range(1)));
         repeat (45) send_item(pick_sample(), ($urandom_range(39) == 0));
      end
   endtask

   // receiver holds off while items keep coming, so the input stalls
   task automatic test_backpressure();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      write_csr(wmr_pkg::CSR_WINDOW_LENGTH, 32'd8);
      hold_requests++;
      repeat (24) send_item(pick_sample(), 1'b0);
   endtask

   initial begin
      cfg_len = wmr_pkg::LEN_RESET;
      cfg_rms = 1'b0;
      clear_totals();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_cleared_state();
      test_plain_extremes();
      test_square_extremes();
      test_length_limits();
      test_mode_switch();
      test_window_fill();
      test_random_traffic(0, 0);
      test_random_traffic(78, 0);
      test_random_traffic(0, 78);
      test_random_traffic(31, 31);
      test_backpressure();

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
